// File: rtl/depth_grid_triangulator_macros.svh
// depth_grid_triangulator_macros.svh: assertion macros shared by the RTL modules.
// Depends on nothing; each asserting module includes it before its declaration.
`ifndef DEPTH_GRID_TRIANGULATOR_MACROS_SVH
`define DEPTH_GRID_TRIANGULATOR_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DGT_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A property whose consequent must hold in the cycle after its antecedent.
`define DGT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/dgt_pkg.sv
// dgt_pkg: types, constants and helpers of the depth grid triangulator.
// Used by every RTL module of the block; depends on nothing.
package dgt_pkg;

   // Field widths and fixed-point format.
   localparam int DEPTH_BITS     = 24;
   localparam int IDX_BITS       = 20;
   localparam int SIZE_BITS      = 11;
   localparam int RATIO_BITS     = 16;
   localparam int RATIO_FRAC     = 12;
   localparam int MAG_BITS       = DEPTH_BITS + 1;
   localparam int PROD_BITS      = MAG_BITS + RATIO_BITS;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   // Default geometry limits and register reset values.
   localparam int DEF_MAX_ROW_WIDTH = 1024;
   localparam int DEF_MAX_ROW_COUNT = 1024;
   localparam int MIN_SIZE          = 2;
   localparam int RESET_ROW_WIDTH   = 640;
   localparam int RESET_ROW_COUNT   = 480;
   localparam int RESET_BREAK_RATIO = 82;

   // Quad edges in the order the judge unit evaluates them.
   localparam int EDGE_COUNT = 4;
   localparam int E_D1X      = 0;
   localparam int E_D1Y      = 1;
   localparam int E_D2X      = 2;
   localparam int E_D2Y      = 3;

   // Triangle queue depth: room for two items of two triangles each.
   localparam int TRI_FIFO_DEPTH = 4;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ROW_WIDTH   = 2'd0,
      CSR_ROW_COUNT   = 2'd1,
      CSR_BREAK_RATIO = 2'd2
   } csr_index_type;

   typedef logic signed [DEPTH_BITS-1:0] depth_type;
   typedef logic [IDX_BITS-1:0]          index_type;
   typedef logic [MAG_BITS-1:0]          mag_type;
   typedef logic [PROD_BITS-1:0]         prod_type;

   // Input item.
   typedef struct packed {
      depth_type depth;
      logic      depth_valid;
   } req_item_type;

   // Result item: one triangle.
   typedef struct packed {
      index_type vertex_a;
      index_type vertex_b;
      index_type vertex_c;
      logic      last_of_quad;
   } rsp_item_type;

   // Raster indices of the four quad corners.
   typedef struct packed {
      index_type v11;
      index_type v12;
      index_type v21;
      index_type v22;
   } quad_vtx_type;

   // What the pixel front end hands to the judge unit with each item.
   typedef struct packed {
      logic         quad;
      depth_type    z21;
      depth_type    z22;
      quad_vtx_type vtx;
   } quad_ctl_type;

   // Magnitude of a two's-complement value one bit wider than a depth.
   function automatic mag_type abs_mag(input mag_type v);
      abs_mag = v[MAG_BITS-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

// File: rtl/dgt_line_store.sv
// dgt_line_store: the upper-row depth memory, one write and one read port.
// Depends on dgt_pkg and the assertion macros header.
`include "depth_grid_triangulator_macros.svh"

module dgt_line_store
   import dgt_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [$clog2(MAX_ROW_WIDTH)-1:0] wr_addr,
   input  depth_type                        wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(MAX_ROW_WIDTH)-1:0] rd_addr,
   output depth_type                        rd_data
);

   depth_type mem [MAX_ROW_WIDTH];
   depth_type rd_data_ff;

   // Synchronous write and registered read; contents are undefined until written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   // The deferred write always targets a column other than the one being read.
   `DGT_ASSERT_ALWAYS(a_no_rw_collision, clock, reset, !(wr_en && rd_en && (wr_addr == rd_addr)), "line store read and write hit the same entry")

endmodule

// File: rtl/dgt_quad_judge.sv
// dgt_quad_judge: edge break tests and triangle selection for one quad per item.
// Depends on dgt_pkg and the assertion macros header.
`include "depth_grid_triangulator_macros.svh"

module dgt_quad_judge
   import dgt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  quad_ctl_type          in_ctl,
   input  depth_type             upper_depth,
   input  logic [RATIO_BITS-1:0] break_ratio,
   output logic [1:0]            push_count,
   output rsp_item_type          push_tri0,
   output rsp_item_type          push_tri1
);

   // Stage B: item beside its line store read.
   logic         b_valid_ff;
   quad_ctl_type b_ctl_ff;
   depth_type    ul_depth_ff;

   // Stage C: edge magnitudes.
   logic         c_valid_ff;
   logic         c_quad_ff;
   quad_vtx_type c_vtx_ff;
   logic         c_zero_ff [EDGE_COUNT];
   mag_type      c_diff_ff [EDGE_COUNT];
   mag_type      c_sum_ff  [EDGE_COUNT];
   logic         c_zero_in [EDGE_COUNT];
   mag_type      c_diff_in [EDGE_COUNT];
   mag_type      c_sum_in  [EDGE_COUNT];

   // Stage D: scaled thresholds.
   logic         d_valid_ff;
   logic         d_quad_ff;
   quad_vtx_type d_vtx_ff;
   logic         d_zero_ff [EDGE_COUNT];
   mag_type      d_diff_ff [EDGE_COUNT];
   prod_type     d_prod_ff [EDGE_COUNT];
   prod_type     d_prod_in [EDGE_COUNT];

   depth_type    za [EDGE_COUNT];
   depth_type    zb [EDGE_COUNT];
   logic         broken [EDGE_COUNT];
   logic         ul, ur, ll, lr;
   logic [1:0]   tri_count;

   // Stage B to D valids; the prior item's upper depth becomes this one's upper-left.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= in_valid;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ctl_ff <= in_ctl;
         if (b_valid_ff) begin
            ul_depth_ff <= upper_depth;
         end
      end
   end

   // Edge endpoints: d1x (11,12), d1y (11,21), d2x (22,21), d2y (22,12).
   always_comb begin
      za[E_D1X] = ul_depth_ff;    zb[E_D1X] = upper_depth;
      za[E_D1Y] = ul_depth_ff;    zb[E_D1Y] = b_ctl_ff.z21;
      za[E_D2X] = b_ctl_ff.z22;   zb[E_D2X] = b_ctl_ff.z21;
      za[E_D2Y] = b_ctl_ff.z22;   zb[E_D2Y] = upper_depth;
   end

   // Absolute difference and absolute sum of each edge's depths.
   always_comb begin
      for (int i = 0; i < EDGE_COUNT; i++) begin
         c_zero_in[i] = (za[i] == '0) || (zb[i] == '0);
         c_diff_in[i] = abs_mag({za[i][DEPTH_BITS-1], za[i]} - {zb[i][DEPTH_BITS-1], zb[i]});
         c_sum_in[i]  = abs_mag({za[i][DEPTH_BITS-1], za[i]} + {zb[i][DEPTH_BITS-1], zb[i]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_quad_ff <= b_valid_ff && b_ctl_ff.quad;
         c_vtx_ff  <= b_ctl_ff.vtx;
         for (int i = 0; i < EDGE_COUNT; i++) begin
            c_zero_ff[i] <= c_zero_in[i];
            c_diff_ff[i] <= c_diff_in[i];
            c_sum_ff[i]  <= c_sum_in[i];
         end
      end
   end

   // Threshold ratio*|za+zb|, one narrow multiplier per edge.
   always_comb begin
      for (int i = 0; i < EDGE_COUNT; i++) begin
         d_prod_in[i] = break_ratio * c_sum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_quad_ff <= c_quad_ff;
         d_vtx_ff  <= c_vtx_ff;
         for (int i = 0; i < EDGE_COUNT; i++) begin
            d_zero_ff[i] <= c_zero_ff[i];
            d_diff_ff[i] <= c_diff_ff[i];
            d_prod_ff[i] <= d_prod_in[i];
         end
      end
   end

   // An edge breaks on a zero depth or when |za-zb|*4096 exceeds the threshold.
   always_comb begin
      for (int i = 0; i < EDGE_COUNT; i++) begin
         broken[i] = d_zero_ff[i] ||
                     (PROD_BITS'({d_diff_ff[i], {RATIO_FRAC{1'b0}}}) > d_prod_ff[i]);
      end
      ul = broken[E_D1X] || broken[E_D1Y];
      ur = broken[E_D1X] || broken[E_D2Y];
      ll = broken[E_D2X] || broken[E_D1Y];
      lr = broken[E_D2X] || broken[E_D2Y];
   end

   // Triangle selection; the first matching corner case wins.
   always_comb begin
      tri_count = 2'd0;
      push_tri0 = '{vertex_a: d_vtx_ff.v12, vertex_b: d_vtx_ff.v21,
                    vertex_c: d_vtx_ff.v22, last_of_quad: 1'b1};
      push_tri1 = '{vertex_a: d_vtx_ff.v11, vertex_b: d_vtx_ff.v21,
                    vertex_c: d_vtx_ff.v12, last_of_quad: 1'b1};
      priority if (ul && !lr) begin
         tri_count = 2'd1;
      end else if (!ul && lr) begin
         tri_count = 2'd1;
         push_tri0 = '{vertex_a: d_vtx_ff.v11, vertex_b: d_vtx_ff.v21,
                       vertex_c: d_vtx_ff.v12, last_of_quad: 1'b1};
      end else if (!ur && ll) begin
         tri_count = 2'd1;
         push_tri0 = '{vertex_a: d_vtx_ff.v11, vertex_b: d_vtx_ff.v22,
                       vertex_c: d_vtx_ff.v12, last_of_quad: 1'b1};
      end else if (ur && !ll) begin
         tri_count = 2'd1;
         push_tri0 = '{vertex_a: d_vtx_ff.v11, vertex_b: d_vtx_ff.v21,
                       vertex_c: d_vtx_ff.v22, last_of_quad: 1'b1};
      end else if (!ul && !lr) begin
         tri_count = 2'd2;
         push_tri0.last_of_quad = 1'b0;
      end else begin
         tri_count = 2'd0;
      end
   end

   // Triangles leave only when the whole pipe moves.
   assign push_count = (advance && d_valid_ff && d_quad_ff) ? tri_count : 2'd0;

   // A pair of triangles always closes on the second one, and never more than two.
   `DGT_ASSERT_ALWAYS(a_pair_order, clock, reset, (push_count != 2'd3) && ((push_count != 2'd2) || (!push_tri0.last_of_quad && push_tri1.last_of_quad)), "bad triangle pair from quad judge")

endmodule

// File: rtl/dgt_tri_fifo.sv
// dgt_tri_fifo: small triangle queue that takes up to two triangles per cycle.
// Depends on dgt_pkg and the assertion macros header.
`include "depth_grid_triangulator_macros.svh"

module dgt_tri_fifo
   import dgt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_count,
   input  rsp_item_type push_tri0,
   input  rsp_item_type push_tri1,
   output logic         room,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int PTR_W = $clog2(TRI_FIFO_DEPTH);
   localparam int CNT_W = $clog2(TRI_FIFO_DEPTH + 1);

   rsp_item_type     entry_ff [TRI_FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] after_pop;
   logic             pop;

   // Head of the queue drives the result channel.
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   // The pipe may move when two slots are free once this cycle's pop is counted.
   assign after_pop = cnt_ff - CNT_W'(pop);
   assign room      = (after_pop <= CNT_W'(TRI_FIFO_DEPTH - 2));

   always_comb begin
      cnt_in    = after_pop + CNT_W'(push_count);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // Storage writes at the tail, the second triangle one slot behind the first.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_tri0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_ff + PTR_W'(1)] <= push_tri1;
      end
   end

   // Pushes are gated by the room flag, so the fill level stays within the depth.
   `DGT_ASSERT_ALWAYS(a_fifo_bound, clock, reset, cnt_ff <= CNT_W'(TRI_FIFO_DEPTH), "triangle queue overflow")

endmodule

// File: rtl/depth_grid_triangulator.sv
// depth_grid_triangulator: top level, pixel raster tracking, config and wiring.
// Depends on dgt_pkg, dgt_line_store, dgt_quad_judge, dgt_tri_fifo and the macros header.
//
//   Channel   Direction  Payload              Handshake
//   req_      in         req_item_type        req_valid / req_ready
//   rsp_      out        rsp_item_type        rsp_valid / rsp_ready
//   csr_      in         csr_index, csr_wdata csr_valid / csr_ready (always ready)
//
// A pixel item is taken every cycle while the triangle queue has two free slots; its
// triangles, if any, pass stage registers B, C and D into the queue, which drives rsp_
// with one per cycle while rsp_ready is high. Sustained throughput is set by the single
// result port draining the four-entry triangle queue, so quads that yield two triangles
// slow the input. Reset clears counters and pipeline valids and loads the config
// defaults; the line store is not cleared. A stall on rsp_ holds the whole pipe once
// the queue lacks two free slots, and req_ready drops with it.
`include "depth_grid_triangulator_macros.svh"

module depth_grid_triangulator
   import dgt_pkg::*;
#(
   parameter int MAX_ROW_WIDTH = DEF_MAX_ROW_WIDTH,
   parameter int MAX_ROW_COUNT = DEF_MAX_ROW_COUNT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_item_type              req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_item_type              rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_ROW_WIDTH);
   localparam int ROW_W = $clog2(MAX_ROW_COUNT);
   localparam int WID_W = $clog2(MAX_ROW_WIDTH + 1);
   localparam int HGT_W = $clog2(MAX_ROW_COUNT + 1);
   localparam int WCMP_W = (WID_W > SIZE_BITS) ? WID_W : SIZE_BITS;
   localparam int HCMP_W = (HGT_W > SIZE_BITS) ? HGT_W : SIZE_BITS;

   // Configuration registers.
   logic [SIZE_BITS-1:0]  row_width_ff;
   logic [SIZE_BITS-1:0]  row_count_ff;
   logic [RATIO_BITS-1:0] break_ratio_ff;

   // Raster position and neighbor state.
   logic [COL_W-1:0] col_ff, col_in;
   logic [COL_W-1:0] prev_col_ff, prev_col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   index_type        pix_ff, pix_in;
   depth_type        left_ff, left_in;
   logic             prev_ok_ff, prev_ok_in;

   logic [WCMP_W-1:0] w_wide;
   logic [HCMP_W-1:0] h_wide;
   logic [WID_W-1:0]  w_size;
   logic [HGT_W-1:0]  h_size;
   index_type         w_idx;
   logic              eol;
   logic              last_row;
   logic              accept;
   logic              advance;
   depth_type         z_cur;
   depth_type         upper_depth;
   quad_ctl_type      ctl;
   logic [1:0]        push_count;
   rsp_item_type      push_tri0;
   rsp_item_type      push_tri1;

   // Register writes; the port never stalls.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff   <= SIZE_BITS'(RESET_ROW_WIDTH);
         row_count_ff   <= SIZE_BITS'(RESET_ROW_COUNT);
         break_ratio_ff <= RATIO_BITS'(RESET_BREAK_RATIO);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_WIDTH:   row_width_ff   <= csr_wdata[SIZE_BITS-1:0];
            CSR_ROW_COUNT:   row_count_ff   <= csr_wdata[SIZE_BITS-1:0];
            CSR_BREAK_RATIO: break_ratio_ff <= csr_wdata[RATIO_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Image size saturated to the supported range.
   always_comb begin
      w_wide = WCMP_W'(row_width_ff);
      h_wide = HCMP_W'(row_count_ff);
      if (w_wide < WCMP_W'(MIN_SIZE)) begin
         w_size = WID_W'(MIN_SIZE);
      end else if (w_wide > WCMP_W'(MAX_ROW_WIDTH)) begin
         w_size = WID_W'(MAX_ROW_WIDTH);
      end else begin
         w_size = WID_W'(w_wide);
      end
      if (h_wide < HCMP_W'(MIN_SIZE)) begin
         h_size = HGT_W'(MIN_SIZE);
      end else if (h_wide > HCMP_W'(MAX_ROW_COUNT)) begin
         h_size = HGT_W'(MAX_ROW_COUNT);
      end else begin
         h_size = HGT_W'(h_wide);
      end
   end

   // Input handshake follows the pipe advance.
   assign req_ready = advance;
   assign accept    = req_valid && req_ready;

   // Current pixel, row boundaries and quad corner indices.
   always_comb begin
      z_cur    = req_data.depth_valid ? req_data.depth : '0;
      eol      = (WID_W'(col_ff) + WID_W'(1)) >= w_size;
      last_row = (HGT_W'(row_ff) + HGT_W'(1)) >= h_size;
      w_idx    = IDX_BITS'(w_size);
      ctl.quad    = (col_ff != '0) && (row_ff != '0);
      ctl.z21     = left_ff;
      ctl.z22     = z_cur;
      ctl.vtx.v22 = pix_ff;
      ctl.vtx.v21 = pix_ff - IDX_BITS'(1);
      ctl.vtx.v12 = pix_ff - w_idx;
      ctl.vtx.v11 = pix_ff - w_idx - IDX_BITS'(1);
   end

   // Raster counters; the previous column is written back one item later.
   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      pix_in      = pix_ff;
      left_in     = left_ff;
      prev_col_in = prev_col_ff;
      prev_ok_in  = prev_ok_ff;
      if (accept) begin
         left_in     = z_cur;
         prev_col_in = col_ff;
         prev_ok_in  = 1'b1;
         pix_in      = pix_ff + IDX_BITS'(1);
         col_in      = col_ff + COL_W'(1);
         if (eol) begin
            col_in = '0;
            if (last_row) begin
               row_in = '0;
               pix_in = '0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         pix_ff      <= '0;
         left_ff     <= '0;
         prev_col_ff <= '0;
         prev_ok_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         pix_ff      <= pix_in;
         left_ff     <= left_in;
         prev_col_ff <= prev_col_in;
         prev_ok_ff  <= prev_ok_in;
      end
   end

   // Upper row store: read this column, write back the left neighbor's column.
   dgt_line_store #(
      .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && prev_ok_ff),
      .wr_addr (prev_col_ff),
      .wr_data (left_ff),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (upper_depth)
   );

   // Edge tests and triangle selection.
   dgt_quad_judge u_quad_judge (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (accept),
      .in_ctl      (ctl),
      .upper_depth (upper_depth),
      .break_ratio (break_ratio_ff),
      .push_count  (push_count),
      .push_tri0   (push_tri0),
      .push_tri1   (push_tri1)
   );

   // Triangle queue in front of the result channel.
   dgt_tri_fifo u_tri_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_tri0  (push_tri0),
      .push_tri1  (push_tri1),
      .room       (advance),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   // The last pixel of a row sends the column back to zero.
   `DGT_ASSERT_NEXT(a_row_wrap, clock, reset, accept && eol, col_ff == '0, "no row wrap")

endmodule
